@@ sv/wstc_pkg.sv @@
// wstc_pkg: shared types and constants for the weighted spread trust check
// no dependencies; used by every module of the block
package wstc_pkg;

	localparam int MaxHyp = 256;
	localparam int AddrW  = $clog2(MaxHyp);
	localparam int CntW   = AddrW + 1;

	localparam int MeanSteps  = 16;
	localparam int TraceSteps = 34;

	localparam logic [33:0] TraceMax       = 34'h3FFFFFFFF;
	localparam logic [33:0] TraceLimitRst  = 34'd250000;
	localparam logic [15:0] AgeLimitRst    = 16'd3000;

	// configuration register indexes
	localparam logic CfgTraceLimit = 1'b0;
	localparam logic CfgAgeLimit   = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETTLE,
		S_MINIT,
		S_MEAN,
		S_PASS,
		S_TINIT,
		S_TRACE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic mean_init;
		logic mean_step;
		logic pass_rd;
		logic trace_init;
		logic trace_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic            last_beat;
		logic            none;
		logic            out_busy;
		logic [CntW-1:0] count;
	} stat_t;

endpackage

@@ sv/wstc_if.sv @@
// wstc_if: hypothesis and result channel interfaces
// depends on nothing; payload widths are fixed by the field formats
interface wstc_hyp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_mm;
	logic signed [15:0] y_mm;
	logic        [15:0] weight;
	logic               last;
	logic               calibrated;
	logic        [15:0] age_ms;

	modport source (output valid, x_mm, y_mm, weight, last, calibrated,
		age_ms, input ready);
	modport sink (input valid, x_mm, y_mm, weight, last, calibrated,
		age_ms, output ready);
endinterface

interface wstc_res_if;
	logic        valid;
	logic        ready;
	logic [33:0] trace_mm2;
	logic        no_weight;
	logic        trusted;

	modport source (output valid, trace_mm2, no_weight, trusted, input ready);
	modport sink (input valid, trace_mm2, no_weight, trusted, output ready);
endinterface

@@ sv/wstc_ctrl.sv @@
// wstc_ctrl: sequencer for collect, mean, variance pass, trace divide, output
// depends on wstc_pkg
module wstc_ctrl
	import wstc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  stat_t  st,
	output cmd_t   cmd,
	output state_t state
);

	state_t          state_q, state_d;
	logic [CntW-1:0] cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (st.last_beat) state_d = S_SETTLE;
			S_SETTLE: state_d = st.none ? S_DONE : S_MINIT;
			S_MINIT:  state_d = S_MEAN;
			S_MEAN:   if (cnt_q == CntW'(MeanSteps - 1)) state_d = S_PASS;
			S_PASS:   if (cnt_q == st.count + CntW'(2)) state_d = S_TINIT;
			S_TINIT:  state_d = S_TRACE;
			S_TRACE:  if (cnt_q == CntW'(TraceSteps - 1)) state_d = S_DONE;
			S_DONE:   if (!st.out_busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd            = '0;
		cmd.accept     = (state_q == S_IDLE);
		cmd.mean_init  = (state_q == S_MINIT);
		cmd.mean_step  = (state_q == S_MEAN);
		cmd.pass_rd    = (state_q == S_PASS) && (cnt_q < st.count);
		cmd.trace_init = (state_q == S_TINIT);
		cmd.trace_step = (state_q == S_TRACE);
		cmd.out_load   = (state_q == S_DONE) && !st.out_busy;
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q != state_d) ? '0 : cnt_q + CntW'(1);
		end
	end

	assign state = state_q;

endmodule

@@ sv/wstc_dp.sv @@
// wstc_dp: hypothesis store, weighted sums, mean and trace dividers, result register
// depends on wstc_pkg and the channel interfaces
module wstc_dp
	import wstc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [33:0] cfg_wdata,
	wstc_hyp_if.sink    hyp,
	wstc_res_if.source  res
);

	logic [47:0]        mem [MaxHyp];
	logic [CntW-1:0]    count_q;
	logic signed [47:0] sum_x_q, sum_y_q;
	logic [23:0]        sum_w_q;
	logic signed [32:0] px_s1, py_s1;
	logic [23:0]        w_s1;
	logic               v_s1;
	logic               calib_q;
	logic [15:0]        age_q;
	logic [33:0]        trace_limit_q;
	logic [15:0]        age_limit_q;
	logic               fire, take;

	assign hyp.ready = cmd.accept;
	assign fire = hyp.valid && cmd.accept;
	assign take = fire && (hyp.weight != 16'd0) && (count_q < CntW'(MaxHyp));

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_limit_q <= TraceLimitRst;
			age_limit_q   <= AgeLimitRst;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgTraceLimit: trace_limit_q <= cfg_wdata;
				CfgAgeLimit:   age_limit_q   <= cfg_wdata[15:0];
				default:       ;
			endcase
		end
	end

	// store write
	always_ff @(posedge clk) begin
		if (take) mem[count_q[AddrW-1:0]] <= {hyp.x_mm, hyp.y_mm, hyp.weight};
	end

	// product stage for the running sums
	always_ff @(posedge clk) begin
		px_s1 <= hyp.x_mm * $signed({1'b0, hyp.weight});
		py_s1 <= hyp.y_mm * $signed({1'b0, hyp.weight});
		w_s1  <= {8'd0, hyp.weight};
		if (fire && hyp.last) begin
			calib_q <= hyp.calibrated;
			age_q   <= hyp.age_ms;
		end
	end

	// count and sums, cleared when the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			count_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_w_q <= '0;
		end else begin
			v_s1 <= take;
			if (cmd.out_load) begin
				count_q <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_w_q <= '0;
			end else begin
				if (take) count_q <= count_q + CntW'(1);
				if (v_s1) begin
					sum_x_q <= sum_x_q + 48'(px_s1);
					sum_y_q <= sum_y_q + 48'(py_s1);
					sum_w_q <= sum_w_q + w_s1;
				end
			end
		end
	end

	// mean dividers: floor((2S + W + W*2^16) / 2W), offset by 2^15
	logic [24:0]        dvs;
	logic signed [49:0] nx, ny;
	logic [24:0]        remx_q, remy_q;
	logic [15:0]        qx_q, qy_q;
	logic [25:0]        tx, ty;
	logic signed [15:0] mean_x, mean_y;

	assign dvs = {sum_w_q, 1'b0};
	assign nx  = {sum_x_q[47], sum_x_q, 1'b0} + $signed({26'd0, sum_w_q})
		+ $signed({10'd0, sum_w_q, 16'd0});
	assign ny  = {sum_y_q[47], sum_y_q, 1'b0} + $signed({26'd0, sum_w_q})
		+ $signed({10'd0, sum_w_q, 16'd0});
	assign tx  = {remx_q, qx_q[15]};
	assign ty  = {remy_q, qy_q[15]};
	assign mean_x = $signed(qx_q ^ 16'h8000);
	assign mean_y = $signed(qy_q ^ 16'h8000);

	always_ff @(posedge clk) begin
		if (cmd.mean_init) begin
			remx_q <= nx[40:16];
			remy_q <= ny[40:16];
			qx_q   <= nx[15:0];
			qy_q   <= ny[15:0];
		end else if (cmd.mean_step) begin
			if (tx >= {1'b0, dvs}) begin
				remx_q <= 25'(tx - {1'b0, dvs});
				qx_q   <= {qx_q[14:0], 1'b1};
			end else begin
				remx_q <= tx[24:0];
				qx_q   <= {qx_q[14:0], 1'b0};
			end
			if (ty >= {1'b0, dvs}) begin
				remy_q <= 25'(ty - {1'b0, dvs});
				qy_q   <= {qy_q[14:0], 1'b1};
			end else begin
				remy_q <= ty[24:0];
				qy_q   <= {qy_q[14:0], 1'b0};
			end
		end
	end

	// variance pass: read, square, weight, accumulate
	logic [AddrW-1:0]   pass_addr;
	logic [47:0]        rd_s1;
	logic               rv_s1, v_s2, v_s3;
	logic signed [16:0] dx, dy;
	logic signed [33:0] dx2, dy2;
	logic [32:0]        sq_s2;
	logic [15:0]        w_s2;
	logic [48:0]        prod_s3;
	logic [57:0]        acc_q;

	assign dx  = {rd_s1[47], rd_s1[47:32]} - {mean_x[15], mean_x};
	assign dy  = {rd_s1[31], rd_s1[31:16]} - {mean_y[15], mean_y};
	assign dx2 = dx * dx;
	assign dy2 = dy * dy;

	// read address runs with the pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_addr <= '0;
			rv_s1     <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
		end else begin
			if (cmd.mean_init) pass_addr <= '0;
			else if (cmd.pass_rd) pass_addr <= pass_addr + AddrW'(1);
			rv_s1 <= cmd.pass_rd;
			v_s2  <= rv_s1;
			v_s3  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_rd) rd_s1 <= mem[pass_addr];
		sq_s2   <= dx2[32:0] + dy2[32:0];
		w_s2    <= rd_s1[15:0];
		prod_s3 <= sq_s2 * w_s2;
	end

	always_ff @(posedge clk) begin
		if (cmd.mean_init) acc_q <= '0;
		else if (v_s3) acc_q <= acc_q + 58'(prod_s3);
	end

	// trace divider: acc / W, saturating
	logic [23:0] trem_q;
	logic [33:0] tq_q;
	logic        sat_q;
	logic [24:0] tt;

	assign tt = {trem_q, tq_q[33]};

	always_ff @(posedge clk) begin
		if (cmd.trace_init) begin
			sat_q  <= acc_q[57:34] >= sum_w_q;
			trem_q <= acc_q[57:34];
			tq_q   <= acc_q[33:0];
		end else if (cmd.trace_step) begin
			if (tt >= {1'b0, sum_w_q}) begin
				trem_q <= 24'(tt - {1'b0, sum_w_q});
				tq_q   <= {tq_q[32:0], 1'b1};
			end else begin
				trem_q <= tt[23:0];
				tq_q   <= {tq_q[32:0], 1'b0};
			end
		end
	end

	// result register
	logic        none;
	logic [33:0] trace;
	logic        out_valid_q;
	logic [33:0] trace_q;
	logic        none_q, trusted_q;

	assign none  = (sum_w_q == 24'd0);
	assign trace = (none || sat_q) ? TraceMax : tq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (res.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			trace_q   <= trace;
			none_q    <= none;
			trusted_q <= calib_q && (age_q <= age_limit_q) && (trace < trace_limit_q);
		end
	end

	assign res.valid     = out_valid_q;
	assign res.trace_mm2 = trace_q;
	assign res.no_weight = none_q;
	assign res.trusted   = trusted_q;

	// a beat still in the product stage counts as weight
	assign st.last_beat = fire && hyp.last;
	assign st.none      = none && !v_s1;
	assign st.out_busy  = out_valid_q && !res.ready;
	assign st.count     = count_q;

endmodule

@@ sv/weighted_spread_trust_check.sv @@
// weighted_spread_trust_check: top level, controller plus datapath
// depends on wstc_pkg, wstc_if, wstc_ctrl and wstc_dp
//
// Usage: hypotheses arrive on hyp as valid/ready beats; one beat per cycle is
// taken while collecting. Beats with nonzero weight are stored (up to 256) and
// summed; zero-weight beats only count for last. The beat with last set ends
// the set, and its calibrated flag and age_ms are latched.
// After last, hyp.ready stays low while the block works: a settle state, the
// init and steps of the two mean dividers (run side by side), the variance
// pass over the N stored entries (one store read per cycle, pipelined
// squaring and weighting), the init and steps of the trace divider, then
// the load of the result register. An empty set goes from the settle state
// straight to the load.
// The result waits in its register for res.ready; a new set can be collected
// meanwhile, but the next result is held back until the slot is free.
// Reset clears the set and loads trace_limit_mm2 = 250000, age_limit_ms = 3000.
// The store needs no clearing: only entries written in this set are read.
module weighted_spread_trust_check
	import wstc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	wstc_hyp_if.sink    hyp,
	wstc_res_if.source  res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [33:0] cfg_wdata
);

	cmd_t   cmd;
	stat_t  st;
	state_t state;

	wstc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd),
		.state  (state)
	);

	wstc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.hyp       (hyp),
		.res       (res)
	);

	// empty set reports full-scale trace and is never trusted
	a_none_max: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.no_weight |-> res.trace_mm2 == TraceMax && !res.trusted)
		else $error("no_weight result without saturated trace");

	// the last beat closes the input until the result is loaded
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hyp.valid && hyp.ready && hyp.last |=> !hyp.ready)
		else $error("input taken right after last beat");

	// a result is only loaded from the done state
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> state == S_DONE && !$past(state == S_IDLE))
		else $error("result load outside done state");

endmodule

@@ verif/testbench.sv @@
// testbench: random and directed check of weighted_spread_trust_check
// depends on wstc_pkg, wstc_if and the block's rtl; predicts each set's result itself

// expected results of hypothesis sets, with a copy of the set state and limits
class spread_scoreboard;
	int signed   hyp_x[$];
	int signed   hyp_y[$];
	int unsigned hyp_w[$];
	longint      sum_wx;
	longint      sum_wy;
	longint      sum_w;
	logic [33:0] trace_limit;
	logic [15:0] age_limit;
	logic [33:0] exp_trace[$];
	logic        exp_none[$];
	logic        exp_trusted[$];
	int          errors;

	function new();
		trace_limit = 34'd250000;
		age_limit   = 16'd3000;
		errors      = 0;
		clear_set();
	endfunction

	function void clear_set();
		hyp_x.delete();
		hyp_y.delete();
		hyp_w.delete();
		sum_wx = 0;
		sum_wy = 0;
		sum_w  = 0;
	endfunction

	function longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) q = q - 1;
		return q;
	endfunction

	// note one accepted hypothesis beat
	function void add_beat(logic signed [15:0] x, logic signed [15:0] y, logic [15:0] w,
			logic lst, logic cal, logic [15:0] age);
		longint mx;
		longint my;
		longint dx;
		longint dy;
		logic [63:0] acc;
		logic [63:0] tr;
		logic none;
		if (w != 0 && hyp_w.size() < 256) begin
			hyp_x.push_back(x);
			hyp_y.push_back(y);
			hyp_w.push_back(w);
			sum_wx += longint'(x) * longint'(w);
			sum_wy += longint'(y) * longint'(w);
			sum_w  += longint'(w);
		end
		if (!lst) return;
		none = (sum_w == 0);
		if (none) tr = 64'h3FFFFFFFF;
		else begin
			mx = floor_div(2 * sum_wx + sum_w, 2 * sum_w);
			my = floor_div(2 * sum_wy + sum_w, 2 * sum_w);
			acc = 0;
			foreach (hyp_w[i]) begin
				dx = longint'(hyp_x[i]) - mx;
				dy = longint'(hyp_y[i]) - my;
				acc += (dx * dx + dy * dy) * longint'(hyp_w[i]);
			end
			tr = acc / sum_w;
			if (tr > 64'h3FFFFFFFF) tr = 64'h3FFFFFFFF;
		end
		exp_trace.push_back(tr[33:0]);
		exp_none.push_back(none);
		exp_trusted.push_back(cal && age <= age_limit && tr[33:0] < trace_limit);
		clear_set();
	endfunction

	// compare one result beat with the oldest expectation
	function void check_result(logic [33:0] tr, logic none, logic trust);
		if (exp_trace.size() == 0) begin
			$error("unexpected result beat trace_mm2=%0d", tr);
			errors++;
			return;
		end
		if (tr !== exp_trace[0]) begin
			$error("trace_mm2 expected %0d actual %0d", exp_trace[0], tr);
			errors++;
		end
		if (none !== exp_none[0]) begin
			$error("no_weight expected %0d actual %0d", exp_none[0], none);
			errors++;
		end
		if (trust !== exp_trusted[0]) begin
			$error("trusted expected %0d actual %0d", exp_trusted[0], trust);
			errors++;
		end
		void'(exp_trace.pop_front());
		void'(exp_none.pop_front());
		void'(exp_trusted.pop_front());
	endfunction

	function int pending();
		return exp_trace.size();
	endfunction
endclass

module testbench
	import wstc_pkg::*;
;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [33:0] cfg_wdata;
	int          burst_left;
	int          stall_mode;
	int          phase_no;
	int          set_len;
	int          set_kind;
	spread_scoreboard spread_sb;

	wstc_hyp_if hyp ();
	wstc_res_if res ();

	weighted_spread_trust_check u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.hyp       (hyp.sink),
		.res       (res.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// sample beats on both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n && hyp.valid && hyp.ready)
			spread_sb.add_beat(hyp.x_mm, hyp.y_mm, hyp.weight, hyp.last,
				hyp.calibrated, hyp.age_ms);
		if (arst_n && res.valid && res.ready)
			spread_sb.check_result(res.trace_mm2, res.no_weight, res.trusted);
	end

	// receiver stall pattern, mode changes per phase
	always @(negedge clk) begin
		case (stall_mode)
			0: res.ready <= 1'b1;
			1: res.ready <= ($urandom_range(0, 3) != 0);
			2: res.ready <= ($urandom_range(0, 3) == 0);
			default: res.ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// send one hypothesis beat, with bursts and gaps from the sender
	task automatic send_hyp(logic signed [15:0] x, logic signed [15:0] y, logic [15:0] w,
			logic lst, logic cal, logic [15:0] age);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) hyp.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		hyp.valid      <= 1'b1;
		hyp.x_mm       <= x;
		hyp.y_mm       <= y;
		hyp.weight     <= w;
		hyp.last       <= lst;
		hyp.calibrated <= cal;
		hyp.age_ms     <= age;
		@(posedge clk);
		while (!hyp.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// wait for all results, then let the block settle before a write
	task automatic drain();
		hyp.valid <= 1'b0;
		while (spread_sb.pending() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [33:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CfgTraceLimit) spread_sb.trace_limit = val;
		else spread_sb.age_limit = val[15:0];
		@(negedge clk);
	endtask

	// one random set: mostly clustered points, some wide or weightless
	task automatic random_set(int n);
		int cx;
		int cy;
		int spread;
		logic [15:0] w;
		cx = $urandom_range(0, 65535) - 32768;
		cy = $urandom_range(0, 65535) - 32768;
		spread = (1 << $urandom_range(0, 15));
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: w = 16'd0;
				1: w = 16'($urandom_range(0, 65535));
				2: w = 16'hFFFF;
				default: w = 16'($urandom_range(1, 255));
			endcase
			send_hyp((set_kind == 0) ? 16'($urandom) : 16'(cx + int'($urandom_range(0, spread))),
				(set_kind == 0) ? 16'($urandom) : 16'(cy + int'($urandom_range(0, spread))),
				w, i == n - 1, $urandom_range(0, 3) != 0,
				($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 6000)));
		end
	endtask

	initial begin
		spread_sb = new();
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CfgTraceLimit;
		cfg_wdata  = '0;
		hyp.valid  = 1'b0;
		hyp.x_mm   = '0;
		hyp.y_mm   = '0;
		hyp.weight = '0;
		hyp.last   = 1'b0;
		hyp.calibrated = 1'b0;
		hyp.age_ms     = '0;
		res.ready  = 1'b0;
		burst_left = 0;
		stall_mode = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, empty set, zero weights, ties, age and limit edges
		send_hyp(16'sd0, 16'sd0, 16'd0, 1'b1, 1'b1, 16'd0);
		send_hyp(16'sd5, 16'sd5, 16'd0, 1'b0, 1'b1, 16'd0);
		send_hyp(16'sd5, 16'sd5, 16'd0, 1'b1, 1'b1, 16'd0);
		send_hyp(-16'sd32768, -16'sd32768, 16'hFFFF, 1'b0, 1'b1, 16'd3000);
		send_hyp(16'sd32767, 16'sd32767, 16'hFFFF, 1'b1, 1'b1, 16'd3000);
		send_hyp(16'sd100, -16'sd100, 16'd1, 1'b1, 1'b1, 16'd3001);
		send_hyp(16'sd0, 16'sd0, 16'd1, 1'b0, 1'b0, 16'd0);
		send_hyp(16'sd1, -16'sd1, 16'd1, 1'b0, 1'b0, 16'd0);
		send_hyp(16'sd7, 16'sd7, 16'd0, 1'b1, 1'b1, 16'hFFFF);
		send_hyp(-16'sd1, 16'sd2, 16'd3, 1'b0, 1'b0, 16'd0);
		send_hyp(16'sd0, -16'sd3, 16'd2, 1'b1, 1'b1, 16'd1);
		send_hyp(-16'sd32768, 16'sd32767, 16'd1, 1'b0, 1'b0, 16'd0);
		send_hyp(16'sd32767, -16'sd32768, 16'd1, 1'b0, 1'b0, 16'd0);
		send_hyp(16'sd32767, -16'sd32768, 16'hFFFF, 1'b1, 1'b1, 16'd0);
		// store overflow: 260 weighted beats, the tail is dropped
		for (int i = 0; i < 260; i++)
			send_hyp(16'(i * 97), 16'(-i * 31), 16'($urandom_range(1, 65535)),
				i == 259, 1'b1, 16'd10);

		// random phases over several limit settings
		for (phase_no = 0; phase_no < 6; phase_no++) begin
			drain();
			stall_mode = phase_no % 4;
			case (phase_no)
				0: begin write_cfg(CfgTraceLimit, 34'd0); write_cfg(CfgAgeLimit, 34'd0); end
				1: begin write_cfg(CfgTraceLimit, 34'h3FFFFFFFF);
					write_cfg(CfgAgeLimit, 34'hFFFF); end
				2: begin write_cfg(CfgTraceLimit, 34'd1000); write_cfg(CfgAgeLimit, 34'd3000); end
				3: begin write_cfg(CfgTraceLimit, 34'($urandom) << $urandom_range(0, 2));
					write_cfg(CfgAgeLimit, 34'($urandom_range(0, 65535))); end
				4: begin write_cfg(CfgTraceLimit, 34'd250000); write_cfg(CfgAgeLimit, 34'd1); end
				default: begin write_cfg(CfgTraceLimit, 34'h3FFFFFFFE);
					write_cfg(CfgAgeLimit, 34'd6000); end
			endcase
			for (int k = 0; k < 28; k++) begin
				set_kind = $urandom_range(0, 4);
				set_len  = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 40)
					: $urandom_range(1, 12);
				random_set(set_len);
			end
		end

		hyp.valid <= 1'b0;
		while (spread_sb.pending() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (spread_sb.errors == 0 && spread_sb.pending() == 0) begin
			$display("weighted_spread_trust_check: match");
		end else begin
			$display("weighted_spread_trust_check: mismatch");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#40000000;
		$display("weighted_spread_trust_check: mismatch");
		$finish;
	end
endmodule
